[rtl/delta_list_timer_queue_defines.svh]
// Assertion macros for the delta list timer queue
`ifndef DELTA_LIST_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_DEFINES_SVH
// Implication checked every clock, disabled in reset
`define DLTQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define DLTQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/dltq_pkg.sv]
// ----------------------------------------------------------------------------
// dltq_pkg
// Types and constants shared by the delta list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;
  localparam int DEPTH_DEF        = 16;
  localparam int HANDLE_WIDTH_DEF = 8;
  localparam int TIME_WIDTH_DEF   = 32;
  localparam longint unsigned EMPTY_HEAD = 64'd1000000;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED     = 3'd4,
    ST_NONE      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,   // issue read of entry at scan index
    S_SCAN_CHK,  // examine read data
    S_UP_RD,     // insert: read entry to move up
    S_UP_WR,     // insert: write moved entry
    S_PLACE,     // insert: write new entry
    S_MV_RD,     // cancel/tick: read entry to move down
    S_MV_WR,     // cancel/tick: write moved entry
    S_HEAD_RD,   // read head for result
    S_HEAD_CAP,  // capture head delay
    S_OUT        // load the results
  } state_t;
endpackage

[rtl/dltq_if.sv]
// ----------------------------------------------------------------------------
// dltq_in_if / dltq_out_if
// Valid/ready channels of the delta list timer queue.
// ----------------------------------------------------------------------------
interface dltq_in_if #(parameter int HW = 8, parameter int TW = 32);
  logic          valid;
  logic          ready;
  logic [1:0]    opcode;
  logic [HW-1:0] event_handle;
  logic [TW-1:0] delay_time;
  logic [TW-1:0] now_time;
  modport source  (output valid, opcode, event_handle, delay_time, now_time, input ready);
  modport sink    (input valid, opcode, event_handle, delay_time, now_time, output ready);
  modport monitor (input valid, ready, opcode, event_handle, delay_time, now_time);
endinterface

interface dltq_out_if #(parameter int HW = 8, parameter int TW = 32);
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [HW-1:0] fired_handle;
  logic [TW-1:0] head_delay;
  logic          last_of_run;
  modport source  (output valid, status, fired_handle, head_delay, last_of_run, input ready);
  modport sink    (input valid, status, fired_handle, head_delay, last_of_run, output ready);
  modport monitor (input valid, ready, status, fired_handle, head_delay, last_of_run);
endinterface

[rtl/dltq_ram.sv]
// ----------------------------------------------------------------------------
// dltq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module dltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/delta_list_timer_queue.sv]
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Timer queue kept as a delta list in RAM, one operation at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per operation (insert, cancel, tick, clear).
//   out_ch : one result per insert/cancel/clear; a tick gives one result per
//            fired entry or a single "none fired"; last_of_run marks the end.
// Each entry (relative delay and handle) is one RAM word; a sequencer reads
// it, modifies it and writes it back.
// Each entry scanned passes S_SCAN_RD and S_SCAN_CHK and each entry moved a
// read and a write state; the head is read (S_HEAD_RD, S_HEAD_CAP) before
// S_OUT loads the first result. Clear and a rejected insert go straight to
// the head read. A tick then gives one further result per cycle unless the receiver stalls.
// Throughput: one operation at a time; in_ch.ready is high only in idle,
// which is re-entered at the edge that loads the last result.
// Reset clears the entry count and last tick time; RAM is left as it is.
// A stalled receiver holds the result register and the sequencer waits in
// its output state; no new operation is taken until every result is loaded.
// ----------------------------------------------------------------------------
`include "delta_list_timer_queue_defines.svh"
module delta_list_timer_queue #(
  parameter int DEPTH        = dltq_pkg::DEPTH_DEF,
  parameter int HANDLE_WIDTH = dltq_pkg::HANDLE_WIDTH_DEF,
  parameter int TIME_WIDTH   = dltq_pkg::TIME_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dltq_in_if.sink    in_ch,
  dltq_out_if.source out_ch
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = TIME_WIDTH + HANDLE_WIDTH;
  localparam logic [TIME_WIDTH-1:0] EMPTY_T = TIME_WIDTH'(dltq_pkg::EMPTY_HEAD);
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;

  dltq_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]           count_r;
  logic [TIME_WIDTH-1:0]   last_tick_r;
  dltq_pkg::opcode_t       op_r;
  logic [HANDLE_WIDTH-1:0] hdl_r;
  logic [TIME_WIDTH-1:0]   t_r;      // remaining delay / tick delta
  logic [CW-1:0]           idx_r;    // scan position, then move source
  logic [CW-1:0]           sh_r;     // move destination
  logic                    hit_r;    // insert lands before an entry
  logic                    first_r;  // first move of a cancel
  logic [TIME_WIDTH-1:0]   sv_d_r;   // delay kept from the scan
  logic [HANDLE_WIDTH-1:0] sv_h_r;   // handle kept from the scan
  logic [TIME_WIDTH-1:0]   head_r;

  // fired handles of a tick
  logic [HANDLE_WIDTH-1:0] fbuf_r [DEPTH];
  logic [CW-1:0]           nfire_r;
  logic [CW-1:0]           emit_r;
  dltq_pkg::status_t       st_r;
  dltq_pkg::status_t       st_init;

  // output register
  logic                    ov_r;
  logic [2:0]              ost_r;
  logic [HANDLE_WIDTH-1:0] oh_r;
  logic [TIME_WIDTH-1:0]   od_r;
  logic                    ol_r;

  // RAM port
  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [EW-1:0]           wdata, rdata;
  logic [TIME_WIDTH-1:0]   rd_d;
  logic [HANDLE_WIDTH-1:0] rd_h;

  logic [TIME_WIDTH:0]     csum;
  logic [TIME_WIDTH-1:0]   csum_sat;
  dltq_pkg::opcode_t       in_op;
  logic                    in_acc, out_free, out_load, out_last;
  logic                    scan_end, up_done, mv_done;
  logic                    ins_hit, can_hit, tick_fire, full;
  logic [CW-1:0]           nres;

  dltq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  assign rd_d = rdata[EW-1:HANDLE_WIDTH];
  assign rd_h = rdata[HANDLE_WIDTH-1:0];

  // saturating sum for the successor of a cancelled entry
  assign csum     = {1'b0, rd_d} + {1'b0, sv_d_r};
  assign csum_sat = csum[TIME_WIDTH] ? TMAX : csum[TIME_WIDTH-1:0];

  assign in_ch.ready = (state_r == dltq_pkg::S_IDLE);
  assign out_ch.valid        = ov_r;
  assign out_ch.status       = ost_r;
  assign out_ch.fired_handle = oh_r;
  assign out_ch.head_delay   = od_r;
  assign out_ch.last_of_run  = ol_r;

  assign in_op    = dltq_pkg::opcode_t'(in_ch.opcode);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign full     = (count_r == CW'(DEPTH));
  assign out_free = !ov_r || out_ch.ready;
  assign out_load = (state_r == dltq_pkg::S_OUT) && out_free;
  assign nres     = (st_r == dltq_pkg::ST_FIRED) ? nfire_r : CW'(1);
  assign out_last = (emit_r + CW'(1) == nres);

  // scan and move conditions
  assign scan_end  = (idx_r >= count_r);
  assign up_done   = (sh_r <= idx_r + CW'(1));
  assign mv_done   = (sh_r >= count_r);
  assign ins_hit   = (t_r < rd_d);
  assign can_hit   = (rd_h == hdl_r);
  assign tick_fire = (rd_d <= t_r);

  // status of a newly accepted operation
  always_comb begin
    unique case (in_op)
      dltq_pkg::OP_INSERT: st_init = full ? dltq_pkg::ST_FULL : dltq_pkg::ST_INSERTED;
      dltq_pkg::OP_CANCEL: st_init = dltq_pkg::ST_NOT_FOUND;
      dltq_pkg::OP_TICK:   st_init = dltq_pkg::ST_NONE;
      default:             st_init = dltq_pkg::ST_CLEARED;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dltq_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            dltq_pkg::OP_INSERT:
              state_nxt = full ? dltq_pkg::S_HEAD_RD : dltq_pkg::S_SCAN_RD;
            dltq_pkg::OP_CLEAR: state_nxt = dltq_pkg::S_HEAD_RD;
            default:            state_nxt = dltq_pkg::S_SCAN_RD;
          endcase
        end
      end
      dltq_pkg::S_SCAN_RD: begin
        if (!scan_end) begin
          state_nxt = dltq_pkg::S_SCAN_CHK;
        end else if (op_r == dltq_pkg::OP_INSERT) begin
          state_nxt = dltq_pkg::S_UP_RD;
        end else begin
          state_nxt = dltq_pkg::S_HEAD_RD;
        end
      end
      dltq_pkg::S_SCAN_CHK: begin
        unique case (op_r)
          dltq_pkg::OP_INSERT:
            state_nxt = ins_hit ? dltq_pkg::S_UP_RD : dltq_pkg::S_SCAN_RD;
          dltq_pkg::OP_CANCEL:
            state_nxt = can_hit ? dltq_pkg::S_MV_RD : dltq_pkg::S_SCAN_RD;
          dltq_pkg::OP_TICK:
            state_nxt = tick_fire ? dltq_pkg::S_SCAN_RD : dltq_pkg::S_MV_RD;
          default: state_nxt = dltq_pkg::S_HEAD_RD;
        endcase
      end
      dltq_pkg::S_UP_RD:    state_nxt = up_done ? dltq_pkg::S_PLACE : dltq_pkg::S_UP_WR;
      dltq_pkg::S_UP_WR:    state_nxt = dltq_pkg::S_UP_RD;
      dltq_pkg::S_PLACE:    state_nxt = dltq_pkg::S_HEAD_RD;
      dltq_pkg::S_MV_RD:    state_nxt = mv_done ? dltq_pkg::S_HEAD_RD : dltq_pkg::S_MV_WR;
      dltq_pkg::S_MV_WR:    state_nxt = dltq_pkg::S_MV_RD;
      dltq_pkg::S_HEAD_RD:  state_nxt = dltq_pkg::S_HEAD_CAP;
      dltq_pkg::S_HEAD_CAP: state_nxt = dltq_pkg::S_OUT;
      dltq_pkg::S_OUT: begin
        if (out_load && out_last) begin
          state_nxt = dltq_pkg::S_IDLE;
        end
      end
      default: state_nxt = dltq_pkg::S_IDLE;
    endcase
  end

  // RAM address and write data
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state_r)
      dltq_pkg::S_SCAN_RD: raddr = AW'(idx_r);
      dltq_pkg::S_SCAN_CHK: begin
        // first entry left after a tick becomes the new head
        if (op_r == dltq_pkg::OP_TICK && !tick_fire) begin
          we    = 1'b1;
          waddr = '0;
          wdata = {rd_d - t_r, rd_h};
        end
      end
      dltq_pkg::S_UP_RD: begin
        raddr = AW'(sh_r - CW'(1));
        // successor of the new entry loses the remainder
        if (up_done && hit_r) begin
          we    = 1'b1;
          waddr = AW'(idx_r + CW'(1));
          wdata = {sv_d_r - t_r, sv_h_r};
        end
      end
      dltq_pkg::S_UP_WR: begin
        we    = 1'b1;
        waddr = AW'(sh_r);
        wdata = rdata;
      end
      dltq_pkg::S_PLACE: begin
        we    = 1'b1;
        waddr = AW'(idx_r);
        wdata = {t_r, hdl_r};
      end
      dltq_pkg::S_MV_RD: raddr = AW'(idx_r);
      dltq_pkg::S_MV_WR: begin
        we    = 1'b1;
        waddr = AW'(sh_r);
        wdata = first_r ? {csum_sat, rd_h} : rdata;
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dltq_pkg::S_IDLE;
      count_r     <= '0;
      last_tick_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        dltq_pkg::S_IDLE: begin
          if (in_acc) begin
            op_r    <= in_op;
            hdl_r   <= in_ch.event_handle;
            idx_r   <= '0;
            nfire_r <= '0;
            emit_r  <= '0;
            hit_r   <= 1'b0;
            st_r    <= st_init;
            t_r     <= (in_op == dltq_pkg::OP_TICK) ? in_ch.now_time - last_tick_r
                                                     : in_ch.delay_time;
            if (in_op == dltq_pkg::OP_TICK) begin
              last_tick_r <= in_ch.now_time;
            end
            if (in_op == dltq_pkg::OP_CLEAR) begin
              count_r <= '0;
            end
          end
        end
        dltq_pkg::S_SCAN_RD: begin
          if (scan_end) begin
            if (op_r == dltq_pkg::OP_INSERT) begin
              sh_r <= count_r;
            end
            if (op_r == dltq_pkg::OP_TICK) begin
              count_r <= '0;
            end
          end
        end
        dltq_pkg::S_SCAN_CHK: begin
          unique case (op_r)
            dltq_pkg::OP_INSERT: begin
              if (ins_hit) begin
                hit_r  <= 1'b1;
                sv_d_r <= rd_d;
                sv_h_r <= rd_h;
                sh_r   <= count_r;
              end else begin
                t_r   <= t_r - rd_d;
                idx_r <= idx_r + CW'(1);
              end
            end
            dltq_pkg::OP_CANCEL: begin
              idx_r <= idx_r + CW'(1);
              if (can_hit) begin
                sv_d_r  <= rd_d;
                st_r    <= dltq_pkg::ST_CANCELLED;
                count_r <= count_r - CW'(1);
                sh_r    <= idx_r;
                first_r <= 1'b1;
              end
            end
            dltq_pkg::OP_TICK: begin
              idx_r <= idx_r + CW'(1);
              if (tick_fire) begin
                fbuf_r[AW'(nfire_r)] <= rd_h;
                nfire_r              <= nfire_r + CW'(1);
                st_r                 <= dltq_pkg::ST_FIRED;
                t_r                  <= t_r - rd_d;
              end else begin
                // head already written; move the rest down behind it
                count_r <= count_r - idx_r;
                sh_r    <= CW'(1);
                first_r <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        dltq_pkg::S_UP_WR: sh_r <= sh_r - CW'(1);
        dltq_pkg::S_PLACE: count_r <= count_r + CW'(1);
        dltq_pkg::S_MV_WR: begin
          sh_r    <= sh_r + CW'(1);
          idx_r   <= idx_r + CW'(1);
          first_r <= 1'b0;
        end
        dltq_pkg::S_HEAD_CAP: head_r <= (count_r == '0) ? EMPTY_T : rd_d;
        dltq_pkg::S_OUT: begin
          if (out_free) begin
            emit_r <= emit_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_load) begin
      ov_r  <= 1'b1;
      ost_r <= st_r;
      oh_r  <= (st_r == dltq_pkg::ST_FIRED) ? fbuf_r[AW'(emit_r)] : '0;
      od_r  <= head_r;
      ol_r  <= out_last;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  // Assertions
  `DLTQ_ASSERT_IMP(a_count_range, 1'b1, count_r <= CW'(DEPTH), "entry count beyond depth")
  `DLTQ_ASSERT_IMP(a_busy_ready, state_r != dltq_pkg::S_IDLE, !in_ch.ready, "busy input")
  `DLTQ_ASSERT_NXT(a_out_hold, ov_r && !out_ch.ready, ov_r && $stable(od_r), "result lost")
endmodule

[bench/dltq_tb_if.sv]
// ----------------------------------------------------------------------------
// dltq_tb_if
// Holds the watchdog limit; the channel interfaces come from the RTL's dltq_if.sv.
// ----------------------------------------------------------------------------
package dltq_tb_pkg;
  localparam int WATCHDOG_LIMIT = 20000;
endpackage

[bench/dltq_checker.sv]
// ----------------------------------------------------------------------------
// dltq_checker
// Watches both channels, predicts every result of the delta list timer queue
// and compares each result transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module dltq_checker (
  input  logic        clk,
  input  logic        rst_n,
  dltq_in_if.monitor  in_mon,
  dltq_out_if.monitor out_mon,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDEP = dltq_pkg::DEPTH_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  fired_handle;
    logic [31:0] head_delay;
    logic        last_of_run;
  } timer_result_t;

  // shadow delta list
  logic [31:0]   dl_delay [NDEP];
  logic [7:0]    dl_handle [NDEP];
  int            dl_count;
  logic [31:0]   last_tick;
  timer_result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [31:0] head_now();
    return (dl_count == 0) ? 32'(dltq_pkg::EMPTY_HEAD) : dl_delay[0];
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < dl_count; i++) begin
      dl_delay[i]  = dl_delay[i+1];
      dl_handle[i] = dl_handle[i+1];
    end
    dl_count--;
  endfunction

  // apply one operation to the shadow list and queue its results
  function automatic void predict_timer_op(logic [1:0] op, logic [7:0] h,
                                           logic [31:0] t, logic [31:0] now);
    dltq_pkg::status_t st [NDEP];
    logic [7:0]    fh [NDEP];
    int            nres;
    logic [31:0]   rem, delta;
    logic [32:0]   sum;
    int            i;
    timer_result_t r;
    nres = 0;
    rem  = t;
    case (dltq_pkg::opcode_t'(op))
      dltq_pkg::OP_INSERT: begin
        if (dl_count >= NDEP) begin
          st[nres] = dltq_pkg::ST_FULL; fh[nres] = '0; nres++;
        end else begin
          for (i = 0; i < dl_count; i++) begin
            if (rem < dl_delay[i]) break;
            rem -= dl_delay[i];
          end
          if (i < dl_count) dl_delay[i] -= rem;
          for (int j = dl_count; j > i; j--) begin
            dl_delay[j]  = dl_delay[j-1];
            dl_handle[j] = dl_handle[j-1];
          end
          dl_delay[i] = rem; dl_handle[i] = h; dl_count++;
          st[nres] = dltq_pkg::ST_INSERTED; fh[nres] = '0; nres++;
        end
      end
      dltq_pkg::OP_CANCEL: begin
        for (i = 0; i < dl_count; i++) if (dl_handle[i] == h) break;
        if (i >= dl_count) begin
          st[nres] = dltq_pkg::ST_NOT_FOUND; fh[nres] = '0; nres++;
        end else begin
          rem = dl_delay[i];
          drop_entry(i);
          if (i < dl_count) begin
            sum = {1'b0, dl_delay[i]} + {1'b0, rem};
            dl_delay[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
          st[nres] = dltq_pkg::ST_CANCELLED; fh[nres] = '0; nres++;
        end
      end
      dltq_pkg::OP_TICK: begin
        delta = now - last_tick;
        last_tick = now;
        while (dl_count > 0 && dl_delay[0] <= delta) begin
          delta -= dl_delay[0];
          st[nres] = dltq_pkg::ST_FIRED; fh[nres] = dl_handle[0]; nres++;
          drop_entry(0);
        end
        if (dl_count > 0) dl_delay[0] -= delta;
        if (nres == 0) begin
          st[nres] = dltq_pkg::ST_NONE; fh[nres] = '0; nres++;
        end
      end
      default: begin
        dl_count = 0;
        st[nres] = dltq_pkg::ST_CLEARED; fh[nres] = '0; nres++;
      end
    endcase
    for (int k = 0; k < nres; k++) begin
      r.status       = st[k];
      r.fired_handle = fh[k];
      r.head_delay   = head_now();
      r.last_of_run  = (k == nres - 1);
      expected_results = {expected_results, r};
    end
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      dl_count  = 0;
      last_tick = '0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      // result side first: an output cannot depend on the same-edge input
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction, status %0d", out_mon.status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_mon.status !== want.status ||
              out_mon.fired_handle !== want.fired_handle ||
              out_mon.head_delay !== want.head_delay ||
              out_mon.last_of_run !== want.last_of_run)
            fail_count <= fail_count + 1;
          if (out_mon.status !== want.status)
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
          if (out_mon.fired_handle !== want.fired_handle)
            $error("fired_handle: expected %0d, got %0d",
                   want.fired_handle, out_mon.fired_handle);
          if (out_mon.head_delay !== want.head_delay)
            $error("head_delay: expected %0d, got %0d",
                   want.head_delay, out_mon.head_delay);
          if (out_mon.last_of_run !== want.last_of_run)
            $error("last_of_run: expected %0d, got %0d",
                   want.last_of_run, out_mon.last_of_run);
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_timer_op(in_mon.opcode, in_mon.event_handle,
                         in_mon.delay_time, in_mon.now_time);
    end
  end
endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives timer operations into the delta list timer queue in bursts,
// stalls the result side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  int   idle_cycles = 0;
  bit   hold_off = 1'b0;
  bit   stim_done = 1'b0;
  logic [7:0] used_handles [$];

  dltq_in_if  #(.HW(8), .TW(32)) in_ch ();
  dltq_out_if #(.HW(8), .TW(32)) out_ch ();

  delta_list_timer_queue uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  dltq_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                    .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  // one transaction on the operation channel, held until accepted
  task automatic send_op(dltq_pkg::opcode_t op, logic [7:0] h, logic [31:0] d,
                         logic [31:0] now);
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.event_handle <= h;
    in_ch.delay_time   <= d;
    in_ch.now_time     <= now;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (op == dltq_pkg::OP_INSERT) used_handles = {used_handles, h};
  endtask

  task automatic pause_sender();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    int r;
    if (hold_off) out_ch.ready <= 1'b0;
    else begin
      r = $urandom_range(0, 9);
      out_ch.ready <= (r < 7);
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= dltq_tb_pkg::WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] now_acc;
    int burst, r;
    logic [7:0] h;
    logic [31:0] d;
    bit held;
    held = 1'b0;
    now_acc = '0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= dltq_pkg::OP_CLEAR;
    in_ch.event_handle <= '0;
    in_ch.delay_time   <= '0;
    in_ch.now_time     <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty cases, extremes, equal delays, full list
    send_op(dltq_pkg::OP_TICK, 8'h00, '0, 32'd0);
    send_op(dltq_pkg::OP_CANCEL, 8'hFF, '0, '0);
    send_op(dltq_pkg::OP_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(dltq_pkg::OP_INSERT, 8'h01, 32'hFFFF_FFFF, '0);
    send_op(dltq_pkg::OP_CANCEL, 8'hFF, '0, '0);
    send_op(dltq_pkg::OP_INSERT, 8'h02, 32'd0, '0);
    send_op(dltq_pkg::OP_CANCEL, 8'h02, '0, '0);
    send_op(dltq_pkg::OP_CLEAR, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA);
    for (int i = 0; i < 17; i++)
      send_op(dltq_pkg::OP_INSERT, i[7:0] + 8'h10, 32'(10 * (i % 4)), '0);
    send_op(dltq_pkg::OP_TICK, '0, '0, 32'd15);
    send_op(dltq_pkg::OP_TICK, '0, '0, 32'd10);
    send_op(dltq_pkg::OP_TICK, '0, '0, 32'd5);
    send_op(dltq_pkg::OP_CLEAR, '0, '0, '0);
    now_acc = 32'd5;

    // random part, with a long receiver hold-off early on
    for (int n = 0; n < 300; ) begin
      if (!held && n >= 40) begin
        held = 1'b1;
        hold_off = 1'b1;
        fork
          begin repeat (300) @(negedge clk); hold_off = 1'b0; end
        join_none
      end
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < 300; b++, n++) begin
        r = $urandom_range(0, 99);
        h = $urandom_range(0, 15) == 0 ? 8'($urandom) : 8'($urandom_range(0, 20));
        d = $urandom_range(0, 9) == 0 ? $urandom : 32'($urandom_range(0, 200));
        if (r < 45) send_op(dltq_pkg::OP_INSERT, h, d, $urandom);
        else if (r < 65) begin
          if (used_handles.size() > 0 && $urandom_range(0, 3) != 0)
            h = used_handles[$urandom_range(0, used_handles.size() - 1)];
          send_op(dltq_pkg::OP_CANCEL, h, $urandom, $urandom);
        end else if (r < 95) begin
          now_acc = $urandom_range(0, 19) == 0 ? $urandom :
                    now_acc + 32'($urandom_range(0, 150));
          send_op(dltq_pkg::OP_TICK, 8'($urandom), $urandom, now_acc);
        end else send_op(dltq_pkg::OP_CLEAR, 8'($urandom), $urandom, $urandom);
      end
      pause_sender();
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // verdict once all expectations have drained
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

[delta_list_timer_queue.f]
+incdir+rtl
rtl/dltq_pkg.sv
rtl/dltq_if.sv
rtl/dltq_ram.sv
rtl/delta_list_timer_queue.sv
bench/dltq_tb_if.sv
bench/dltq_checker.sv
bench/tb_top.sv
